// ----- rtl/core/qfctm_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the quadratic form cosine taper mask.
// No dependencies; every other file in rtl/core imports this package.
package qfctm_pkg;

   localparam int COORD_BITS = 16;
   localparam int CSR_DATA_BITS = 48;
   localparam int CSR_INDEX_BITS = 3;
   localparam int DIFF_BITS = COORD_BITS + 1;
   localparam int PAIR_BITS = 2 * DIFF_BITS;
   localparam int TERM_BITS = PAIR_BITS + 16;
   localparam int Q_BITS = TERM_BITS + 2;
   localparam int THR_BITS = 45;

   localparam logic [47:0] CENTER_RESET = 48'h0;
   localparam logic [47:0] DIAG_RESET = 48'h1000_1000_1000;
   localparam logic [47:0] CROSS_RESET = 48'h0;
   localparam logic [31:0] RADIUS_RESET = 32'h0001_0000;
   localparam logic [31:0] TAPER_RESET = 32'h0A00_0000;

   localparam logic [12:0] WEIGHT_FULL = 13'd4096;
   localparam logic [12:0] WEIGHT_NONE = 13'd0;

   // Cosine table generation constants, Q.30.
   localparam longint HALF_PI_Q30 = 64'sd1686629713;
   localparam longint ONE_Q30 = 64'sd1073741824;
   localparam longint COS_DIV [7] = '{2, 12, 30, 56, 90, 132, 182};

   // Reciprocal of 5 for an exact floor division of any 32-bit value.
   localparam logic [31:0] RECIP_FIVE = 32'hCCCC_CCCD;
   localparam int RECIP_SHIFT = 34;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_CENTER = 3'd0,
      CSR_DIAG   = 3'd1,
      CSR_CROSS  = 3'd2,
      CSR_RADIUS = 3'd3,
      CSR_TAPER  = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      REGION_INNER   = 2'd0,
      REGION_BAND    = 2'd1,
      REGION_OUTSIDE = 2'd2
   } region_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] x_coord;
      logic signed [COORD_BITS-1:0] y_coord;
      logic signed [COORD_BITS-1:0] z_coord;
   } req_type;

   typedef struct packed {
      logic [12:0] weight;
      region_type  region;
   } rsp_type;

   typedef struct packed {
      logic                     valid;
      logic signed [Q_BITS-1:0] q;
   } form_type;

   // floor(18432 * r / 5) for the remainder r of a division by five.
   function automatic logic [13:0] thr_fraction(input logic [2:0] rem);
      logic [13:0] val;
      case (rem)
         3'd0: val = 14'd0;
         3'd1: val = 14'd3686;
         3'd2: val = 14'd7372;
         3'd3: val = 14'd11059;
         3'd4: val = 14'd14745;
         default: val = 14'd0;
      endcase
      return val;
   endfunction

endpackage

// ----- rtl/core/qfctm_form.sv -----
`timescale 1ns / 1ps
// Five-stage pipeline that forms the quadratic value q = d'Md in Q.28.
// Depends on qfctm_pkg for the item and result types.
module qfctm_form
   import qfctm_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  req_type                  req,
   input  logic [CSR_DATA_BITS-1:0] center,
   input  logic [CSR_DATA_BITS-1:0] diag,
   input  logic [CSR_DATA_BITS-1:0] cross_terms,
   output form_type                 form_out
);

   logic [4:0] valid_ff;
   logic [4:0] valid_in;

   logic signed [DIFF_BITS-1:0] diff_ff [3];
   logic signed [DIFF_BITS-1:0] diff_in [3];
   logic signed [PAIR_BITS-1:0] pair_ff [6];
   logic signed [PAIR_BITS-1:0] pair_in [6];
   logic signed [TERM_BITS-1:0] term_ff [6];
   logic signed [TERM_BITS-1:0] term_in [6];
   logic signed [TERM_BITS:0]   part_ff [3];
   logic signed [TERM_BITS:0]   part_in [3];
   logic signed [Q_BITS-1:0]    q_ff;
   logic signed [Q_BITS-1:0]    q_in;

   logic signed [COORD_BITS-1:0] coord [3];
   logic signed [15:0]           coef [6];

   assign coord[0] = req.x_coord;
   assign coord[1] = req.y_coord;
   assign coord[2] = req.z_coord;

   // Diagonal terms first, then the cross terms xy, xz, yz.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         coef[i]     = $signed(diag[16*i +: 16]);
         coef[i + 3] = $signed(cross_terms[16*i +: 16]);
      end
   end

   always_comb begin
      valid_in = {valid_ff[3:0], in_valid};
      for (int i = 0; i < 3; i++) begin
         diff_in[i] = DIFF_BITS'(coord[i]) - DIFF_BITS'($signed(center[16*i +: 16]));
      end
      pair_in[0] = diff_ff[0] * diff_ff[0];
      pair_in[1] = diff_ff[1] * diff_ff[1];
      pair_in[2] = diff_ff[2] * diff_ff[2];
      pair_in[3] = diff_ff[0] * diff_ff[1];
      pair_in[4] = diff_ff[0] * diff_ff[2];
      pair_in[5] = diff_ff[1] * diff_ff[2];
      for (int i = 0; i < 6; i++) begin
         term_in[i] = pair_ff[i] * coef[i];
      end
      for (int i = 0; i < 3; i++) begin
         part_in[i] = (TERM_BITS+1)'(term_ff[2*i]) + (TERM_BITS+1)'(term_ff[2*i + 1]);
      end
      q_in = Q_BITS'(part_ff[0]) + Q_BITS'(part_ff[1]) + Q_BITS'(part_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      diff_ff <= diff_in;
      pair_ff <= pair_in;
      term_ff <= term_in;
      part_ff <= part_in;
      q_ff    <= q_in;
   end

   assign form_out.valid = valid_ff[4];
   assign form_out.q     = q_ff;

endmodule

// ----- rtl/core/quadratic_form_cosine_taper_mask.sv -----
`timescale 1ns / 1ps
// Top level of the quadratic form cosine taper mask: registers, band logic, cosine table.
// Depends on qfctm_pkg and qfctm_form.
//
//   channel  ports                        direction  handshake
//   item in  start, busy, req_data        input      start high and busy low
//   result   rsp_valid, rsp_data          output     one-cycle strobe, no back-pressure
//   csr      csr_we, csr_index, csr_wdata input      write on csr_we, no wait
//
// One item is accepted per cycle while busy is low. The nine stages are the center
// subtraction, two multiplier stages and two adder stages of the quadratic form, the
// classification, the taper multiply, the table index and the table read.
// Reset is synchronous and clears every valid bit and the configuration registers;
// busy is high during reset. The pipeline never stalls since results cannot be held off.
module quadratic_form_cosine_taper_mask
   import qfctm_pkg::*;
#(
   parameter int TABLE_ENTRIES = 256
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  req_type                   req_data,
   output logic                      rsp_valid,
   output rsp_type                   rsp_data,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int IDX_BITS = $clog2(TABLE_ENTRIES + 1);
   localparam int PROD_BITS = 41 + IDX_BITS;

   typedef logic [12:0] cos_tab_type [TABLE_ENTRIES + 1];

   // Quarter-wave cosine in Q.30 by a Taylor series through theta^14, rounded to Q.12.
   function automatic cos_tab_type build_cos_tab();
      cos_tab_type tab;
      longint      x;
      longint      theta;
      longint      th2;
      longint      mag;
      longint      acc;
      bit          neg;
      for (int i = 0; i <= TABLE_ENTRIES; i++) begin
         x     = (longint'(i) <<< 30) / TABLE_ENTRIES;
         theta = (x * HALF_PI_Q30) >>> 30;
         th2   = (theta * theta) >>> 30;
         mag   = ONE_Q30;
         acc   = ONE_Q30;
         neg   = 1'b0;
         for (int k = 0; k < 7; k++) begin
            mag = ((mag * th2) >>> 30) / COS_DIV[k];
            neg = !neg;
            acc = neg ? acc - mag : acc + mag;
         end
         if (acc < 0) begin
            acc = 0;
         end
         acc = (acc + (64'sd1 <<< 17)) >>> 18;
         if (acc > 4096) begin
            acc = 4096;
         end
         tab[i] = 13'(acc);
      end
      return tab;
   endfunction

   localparam cos_tab_type COS_TAB = build_cos_tab();

   // Configuration registers.
   logic [47:0] center_ff, center_in;
   logic [47:0] diag_ff, diag_in;
   logic [47:0] cross_ff, cross_in;
   logic [31:0] radius_ff, radius_in;
   logic [31:0] taper_ff, taper_in;

   always_comb begin
      center_in = center_ff;
      diag_in   = diag_ff;
      cross_in  = cross_ff;
      radius_in = radius_ff;
      taper_in  = taper_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_CENTER: center_in = csr_wdata;
            CSR_DIAG:   diag_in   = csr_wdata;
            CSR_CROSS:  cross_in  = csr_wdata;
            CSR_RADIUS: radius_in = csr_wdata[31:0];
            CSR_TAPER:  taper_in  = csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         center_ff <= CENTER_RESET;
         diag_ff   <= DIAG_RESET;
         cross_ff  <= CROSS_RESET;
         radius_ff <= RADIUS_RESET;
         taper_ff  <= TAPER_RESET;
      end else begin
         center_ff <= center_in;
         diag_ff   <= diag_in;
         cross_ff  <= cross_in;
         radius_ff <= radius_in;
         taper_ff  <= taper_in;
      end
   end

   // Inner threshold floor(0.9 * radius * 4096) = floor(radius * 18432 / 5), registered
   // in quot_ff and thr_ff after a radius write, long before an item reaches the compare.
   logic [63:0]  recip_prod;
   logic [29:0]  quot_ff, quot_in;
   logic [31:0]  rad_hold_ff;
   logic [2:0]   rem;
   logic [THR_BITS-1:0] thr_ff, thr_in;

   always_comb begin
      recip_prod = radius_ff * RECIP_FIVE;
      quot_in    = recip_prod[RECIP_SHIFT +: 30];
      rem        = 3'(rad_hold_ff - {quot_ff, 2'b00} - {2'b00, quot_ff});
      thr_in     = {1'b0, quot_ff, 14'b0} + {4'b0, quot_ff, 11'b0}
                 + THR_BITS'(thr_fraction(rem));
   end

   always_ff @(posedge clock) begin
      quot_ff     <= quot_in;
      rad_hold_ff <= radius_ff;
      thr_ff      <= thr_in;
   end

   assign busy = reset;

   form_type form;

   qfctm_form u_form (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (start & ~busy),
      .req         (req_data),
      .center      (center_ff),
      .diag        (diag_ff),
      .cross_terms (cross_ff),
      .form_out    (form)
   );

   // Classification stage. Since the threshold is never negative, a negative q is inner.
   logic signed [Q_BITS-1:0] thr_ext;
   logic signed [Q_BITS-1:0] rad_ext;
   logic signed [Q_BITS-1:0] excess;
   logic       cls_valid_ff;
   region_type cls_region_ff, cls_region_in;
   logic [31:0] cls_e_ff;

   always_comb begin
      thr_ext = $signed({{(Q_BITS-THR_BITS){1'b0}}, thr_ff});
      rad_ext = $signed({{(Q_BITS-44){1'b0}}, radius_ff, 12'b0});
      excess  = form.q - thr_ext;
      if (form.q <= thr_ext) begin
         cls_region_in = REGION_INNER;
      end else if (form.q <= rad_ext) begin
         cls_region_in = REGION_BAND;
      end else begin
         cls_region_in = REGION_OUTSIDE;
      end
   end

   // Taper position t in Q.40, then the rounded table index.
   logic        tap_valid_ff;
   region_type  tap_region_ff;
   logic [63:0] tap_t_ff, tap_t_in;

   logic [40:0]          t_sat;
   logic [PROD_BITS-1:0] idx_prod;
   logic [PROD_BITS-1:0] idx_round;
   logic                 idx_valid_ff;
   region_type           idx_region_ff;
   logic [IDX_BITS-1:0]  idx_ff, idx_in;

   always_comb begin
      tap_t_in  = cls_e_ff * taper_ff;
      t_sat     = (tap_t_ff > (64'd1 << 40)) ? (41'd1 << 40) : tap_t_ff[40:0];
      idx_prod  = PROD_BITS'(t_sat) * PROD_BITS'(TABLE_ENTRIES);
      idx_round = idx_prod + (PROD_BITS'(1) << 39);
      idx_in    = idx_round[40 +: IDX_BITS];
   end

   // Output stage.
   logic    out_valid_ff;
   rsp_type out_ff, out_in;

   always_comb begin
      out_in.region = idx_region_ff;
      case (idx_region_ff)
         REGION_INNER: out_in.weight = WEIGHT_FULL;
         REGION_BAND:  out_in.weight = COS_TAB[idx_ff];
         default:      out_in.weight = WEIGHT_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cls_valid_ff <= 1'b0;
         tap_valid_ff <= 1'b0;
         idx_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         cls_valid_ff <= form.valid;
         tap_valid_ff <= cls_valid_ff;
         idx_valid_ff <= tap_valid_ff;
         out_valid_ff <= idx_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      cls_region_ff <= cls_region_in;
      cls_e_ff      <= excess[43:12];
      tap_region_ff <= cls_region_ff;
      tap_t_ff      <= tap_t_in;
      idx_region_ff <= tap_region_ff;
      idx_ff        <= idx_in;
      out_ff        <= out_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule
